// ===== sv/bblru_pkg.sv =====
// shared types and constants of the byte budget lru cache directory
package bblru_pkg;

    localparam int ENTRIES = 16;
    localparam int IDX_W = $clog2(ENTRIES);
    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam logic [31:0] LIMIT_RESET = 32'd16777216;
    localparam int QDEPTH = 2;

    typedef enum logic [1:0] {
        OP_PUT = 2'd0,
        OP_LOOKUP = 2'd1,
        OP_CLEAR = 2'd2,
        OP_NONE = 2'd3
    } opcode_t;

    typedef enum logic [2:0] {
        ST_EVICTED = 3'd0,
        ST_STORED = 3'd1,
        ST_TOO_LARGE = 3'd2,
        ST_HIT = 3'd3,
        ST_MISS = 3'd4,
        ST_DUPLICATE = 3'd5,
        ST_CLEARED = 3'd6
    } status_t;

    typedef struct packed {
        logic [1:0] opcode;
        logic [31:0] key;
        logic [31:0] size;
    } cmd_t;

    typedef struct packed {
        logic [2:0] status;
        logic [31:0] key;
        logic [31:0] size;
        logic [31:0] used;
        logic last;
    } result_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_SEARCH,
        BK_EVICT,
        BK_STORE,
        BK_EMIT
    } bk_state_t;

endpackage

// ===== sv/byte_budget_lru_cache_directory_unit.sv =====
// top level of the byte budget lru cache directory
// Queue-style channels. Commands enter on push/full (opcode, resource_key,
// resource_size); a transaction is taken when push is high and full is low.
// Results leave on empty/pop: the oldest result sits on status, entry_key,
// entry_size, bytes_used and last while empty is low, taken when pop is high.
// memory_limit (limit_reg) is written over cfg_valid/cfg_ready; the user must
// write it only while the block is idle, which the block does not enforce.
// A two-entry command queue decouples the input side from the sequencer.
// Per command the sequencer dequeues it (IDLE) and searches all keys in
// parallel (SEARCH); a lookup, clear or rejected put then emits its result
// (EMIT). A put evicts one entry per EVICT pass until none is needed, up to
// ENTRIES of them, then stores (STORE) and emits (EMIT). The eviction loop
// is the limit on throughput. A stalled pop holds the result register and
// the sequencer waits; commands keep queuing until the queue is full.
// Reset empties the directory, sets bytes in use to zero and the limit
// to 16777216. Opcode 3 is dropped and produces no result.
module byte_budget_lru_cache_directory_unit
    import bblru_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  opcode,
    input  logic [31:0] resource_key,
    input  logic [31:0] resource_size,
    output logic        empty,
    input  logic        pop,
    output logic [2:0]  status,
    output logic [31:0] entry_key,
    output logic [31:0] entry_size,
    output logic [31:0] bytes_used,
    output logic        last,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data
);

    logic [31:0] limit_reg;
    logic cmd_valid, cmd_take, res_valid;
    cmd_t cmd;
    result_t res;

    // limit register
    assign cfg_ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) limit_reg <= LIMIT_RESET;
        else if (cfg_valid) limit_reg <= cfg_data;
    end

    bblru_front u_front (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .opcode(opcode),
        .resource_key(resource_key), .resource_size(resource_size),
        .cmd_valid(cmd_valid), .cmd(cmd), .cmd_take(cmd_take)
    );

    bblru_back u_back (
        .clk(clk), .rst_n(rst_n), .limit(limit_reg), .cmd_valid(cmd_valid),
        .cmd(cmd), .cmd_take(cmd_take), .res_valid(res_valid), .res(res),
        .res_take(pop)
    );

    // result ports
    assign empty = !res_valid;
    assign status = res.status;
    assign entry_key = res.key;
    assign entry_size = res.size;
    assign bytes_used = res.used;
    assign last = res.last;

    // a held result stays put while stalled
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(entry_key) && $stable(status)))
        else $error("result changed while stalled");

    // eviction results are never final
    a_evict_last: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && status == ST_EVICTED) |-> !last)
        else $error("eviction flagged as last");

    // clear reports zero usage
    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && status == ST_CLEARED) |-> (bytes_used == '0))
        else $error("clear with nonzero usage");

endmodule

// ===== sv/bblru_front.sv =====
// input stage and command queue between front and back
module bblru_front
    import bblru_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  opcode,
    input  logic [31:0] resource_key,
    input  logic [31:0] resource_size,
    output logic        cmd_valid,
    output cmd_t        cmd,
    input  logic        cmd_take
);

    cmd_t q_reg [QDEPTH];
    logic [$clog2(QDEPTH)-1:0] wp_reg, rp_reg;
    logic [$clog2(QDEPTH+1)-1:0] cnt_reg;
    logic do_push, do_pop;

    // unused opcode never enters the queue
    assign full = (cnt_reg == QDEPTH[$clog2(QDEPTH+1)-1:0]);
    assign do_push = push && !full && (opcode != OP_NONE);
    assign cmd_valid = (cnt_reg != '0);
    assign do_pop = cmd_take && cmd_valid;
    assign cmd = q_reg[rp_reg];

    // queue storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            q_reg[wp_reg] <= '{opcode: opcode, key: resource_key, size: resource_size};
        end
    end

    // queue pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= '0;
            rp_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (do_push) wp_reg <= wp_reg + 1'b1;
            if (do_pop) rp_reg <= rp_reg + 1'b1;
            if (do_push && !do_pop) cnt_reg <= cnt_reg + 1'b1;
            else if (do_pop && !do_push) cnt_reg <= cnt_reg - 1'b1;
        end
    end

endmodule

// ===== sv/bblru_back.sv =====
// directory state and the sequencer that carries out one command
module bblru_back
    import bblru_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [31:0] limit,
    input  logic        cmd_valid,
    input  cmd_t        cmd,
    output logic        cmd_take,
    output logic        res_valid,
    output result_t     res,
    input  logic        res_take
);

    bk_state_t state_reg, state_next;
    logic [31:0] keys_reg [ENTRIES];
    logic [31:0] sizes_reg [ENTRIES];
    logic [ENTRIES-1:0] valid_reg;
    logic [IDX_W-1:0] rank_reg [ENTRIES];
    logic [31:0] used_reg;
    logic [CNT_W-1:0] count_reg;
    cmd_t cur_reg;
    result_t res_reg;
    logic res_valid_reg;

    logic hit;
    logic [IDX_W-1:0] hit_idx, old_idx, free_idx;
    logic [31:0] room;
    logic need_evict;
    logic out_free;
    logic emit_now;

    // parallel match, oldest and free slot search over the flop table
    always_comb
    begin
        hit = 1'b0;
        hit_idx = '0;
        old_idx = '0;
        free_idx = '0;
        for (int i = ENTRIES - 1; i >= 0; i--)
        begin
            if (valid_reg[i] && keys_reg[i] == cur_reg.key)
            begin
                hit = 1'b1;
                hit_idx = IDX_W'(i);
            end
            if (!valid_reg[i]) free_idx = IDX_W'(i);
            if (valid_reg[i] && rank_reg[i] == IDX_W'(count_reg - 1'b1)) old_idx = IDX_W'(i);
        end
    end

    assign room = limit - cur_reg.size;
    assign need_evict = (count_reg != '0) &&
        ((used_reg > room) || (count_reg == CNT_W'(ENTRIES)));

    // result register is free when empty or being taken this cycle
    assign out_free = !res_valid_reg || res_take;
    assign emit_now = out_free &&
        ((state_reg == BK_EVICT && need_evict) || (state_reg == BK_EMIT));

    assign res_valid = res_valid_reg;
    assign res = res_reg;
    assign cmd_take = (state_reg == BK_IDLE) && cmd_valid;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE:
                if (cmd_valid) state_next = BK_SEARCH;
            BK_SEARCH:
                if (out_free)
                    state_next = (cur_reg.opcode == OP_PUT && cur_reg.size <= limit && !hit)
                        ? BK_EVICT : BK_EMIT;
            BK_EVICT:
                if (out_free)
                    state_next = need_evict ? BK_EVICT : BK_STORE;
            BK_STORE:
                state_next = BK_EMIT;
            BK_EMIT:
                if (out_free) state_next = BK_IDLE;
            default:
                state_next = BK_IDLE;
        endcase
    end

    // sequencer and directory update
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_IDLE;
            valid_reg <= '0;
            used_reg <= '0;
            count_reg <= '0;
            res_valid_reg <= 1'b0;
            for (int i = 0; i < ENTRIES; i++) rank_reg[i] <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (emit_now) res_valid_reg <= 1'b1;
            else if (res_take) res_valid_reg <= 1'b0;
            case (state_reg)
                BK_IDLE:
                    if (cmd_valid) cur_reg <= cmd;
                BK_SEARCH:
                    if (out_free)
                    begin
                        if (cur_reg.opcode == OP_CLEAR)
                        begin
                            valid_reg <= '0;
                            used_reg <= '0;
                            count_reg <= '0;
                            res_reg <= '{status: ST_CLEARED, key: '0, size: '0,
                                         used: '0, last: 1'b1};
                        end
                        else if (cur_reg.opcode == OP_LOOKUP)
                        begin
                            res_reg <= '{status: hit ? ST_HIT : ST_MISS, key: cur_reg.key,
                                         size: hit ? sizes_reg[hit_idx] : 32'd0,
                                         used: used_reg, last: 1'b1};
                            if (hit)
                            begin
                                for (int i = 0; i < ENTRIES; i++)
                                    if (valid_reg[i] && rank_reg[i] < rank_reg[hit_idx])
                                        rank_reg[i] <= rank_reg[i] + 1'b1;
                                rank_reg[hit_idx] <= '0;
                            end
                        end
                        else if (cur_reg.size > limit)
                        begin
                            res_reg <= '{status: ST_TOO_LARGE, key: cur_reg.key,
                                         size: cur_reg.size, used: used_reg, last: 1'b1};
                        end
                        else if (hit)
                        begin
                            res_reg <= '{status: ST_DUPLICATE, key: cur_reg.key,
                                         size: sizes_reg[hit_idx], used: used_reg,
                                         last: 1'b1};
                        end
                        else
                        begin
                            // a put that passes search must not reuse stale status
                            res_reg.status <= ST_STORED;
                        end
                    end
                BK_EVICT:
                    if (out_free && need_evict)
                    begin
                        valid_reg[old_idx] <= 1'b0;
                        count_reg <= count_reg - 1'b1;
                        used_reg <= used_reg - sizes_reg[old_idx];
                        res_reg <= '{status: ST_EVICTED, key: keys_reg[old_idx],
                                     size: sizes_reg[old_idx],
                                     used: used_reg - sizes_reg[old_idx], last: 1'b0};
                    end
                BK_STORE:
                begin
                    for (int i = 0; i < ENTRIES; i++)
                        if (valid_reg[i]) rank_reg[i] <= rank_reg[i] + 1'b1;
                    rank_reg[free_idx] <= '0;
                    valid_reg[free_idx] <= 1'b1;
                    keys_reg[free_idx] <= cur_reg.key;
                    sizes_reg[free_idx] <= cur_reg.size;
                    count_reg <= count_reg + 1'b1;
                    used_reg <= used_reg + cur_reg.size;
                end
                BK_EMIT:
                    if (out_free && cur_reg.opcode == OP_PUT &&
                        res_reg.status != ST_TOO_LARGE && res_reg.status != ST_DUPLICATE)
                        res_reg <= '{status: ST_STORED, key: cur_reg.key,
                                     size: cur_reg.size, used: used_reg, last: 1'b1};
                default: ;
            endcase
        end
    end

endmodule

// ===== tb/byte_budget_lru_cache_directory_unit_tb.sv =====
// self-checking testbench of the byte budget lru cache directory
`timescale 1ns / 100ps

module byte_budget_lru_cache_directory_unit_tb
    import bblru_pkg::*;
();

    logic        clk;
    logic        rst_n;
    logic        push;
    logic        full;
    logic [1:0]  opcode;
    logic [31:0] resource_key;
    logic [31:0] resource_size;
    logic        empty;
    logic        pop;
    logic [2:0]  status;
    logic [31:0] entry_key;
    logic [31:0] entry_size;
    logic [31:0] bytes_used;
    logic        last;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [31:0] cfg_data;

    byte_budget_lru_cache_directory_unit DUT (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .opcode(opcode),
        .resource_key(resource_key), .resource_size(resource_size),
        .empty(empty), .pop(pop), .status(status), .entry_key(entry_key),
        .entry_size(entry_size), .bytes_used(bytes_used), .last(last),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    // directory mirror
    logic [31:0]    dir_limit;
    logic [31:0]    dir_keys [ENTRIES];
    logic [31:0]    dir_sizes [ENTRIES];
    logic           dir_valid [ENTRIES];
    int unsigned    dir_age [ENTRIES];
    logic [31:0]    dir_bytes;
    result_t        expected_results [$];
    int             error_count;
    int             pop_idle_pct;
    int             push_idle_pct;
    logic [31:0]    recent_keys [$];

    always #10 clk = ~clk;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
        error_count++;
    endtask

    function automatic int oldest_slot();
        int best;
        best = -1;
        for (int i = 0; i < ENTRIES; i++)
            if (dir_valid[i] && (best < 0 || dir_age[i] > dir_age[best]))
                best = i;
        return best;
    endfunction

    function automatic void note(input status_t st, input logic [31:0] k,
                                 input logic [31:0] sz, input logic lst);
        result_t r;
        r.status = st;
        r.key = k;
        r.size = sz;
        r.used = dir_bytes;
        r.last = lst;
        expected_results.insert(expected_results.size(), r);
    endfunction

    // predict the results of one command
    function automatic void predict_command(input opcode_t op, input logic [31:0] k,
                                            input logic [31:0] sz);
        int hit_slot;
        int v;
        int cnt;
        int free_slot;
        hit_slot = -1;
        for (int i = 0; i < ENTRIES; i++)
            if (dir_valid[i] && dir_keys[i] == k && hit_slot < 0)
                hit_slot = i;
        case (op)
            OP_PUT:
            begin
                if (sz > dir_limit)
                    note(ST_TOO_LARGE, k, sz, 1'b1);
                else if (hit_slot >= 0)
                    note(ST_DUPLICATE, k, dir_sizes[hit_slot], 1'b1);
                else
                begin
                    while (dir_bytes > dir_limit - sz && oldest_slot() >= 0)
                    begin
                        v = oldest_slot();
                        dir_valid[v] = 1'b0;
                        dir_bytes -= dir_sizes[v];
                        note(ST_EVICTED, dir_keys[v], dir_sizes[v], 1'b0);
                    end
                    cnt = 0;
                    for (int i = 0; i < ENTRIES; i++)
                        if (dir_valid[i])
                            cnt++;
                    if (cnt >= ENTRIES)
                    begin
                        v = oldest_slot();
                        dir_valid[v] = 1'b0;
                        dir_bytes -= dir_sizes[v];
                        note(ST_EVICTED, dir_keys[v], dir_sizes[v], 1'b0);
                    end
                    free_slot = -1;
                    for (int i = ENTRIES - 1; i >= 0; i--)
                        if (!dir_valid[i])
                            free_slot = i;
                    for (int i = 0; i < ENTRIES; i++)
                        if (dir_valid[i])
                            dir_age[i]++;
                    dir_valid[free_slot] = 1'b1;
                    dir_keys[free_slot] = k;
                    dir_sizes[free_slot] = sz;
                    dir_age[free_slot] = 0;
                    dir_bytes += sz;
                    note(ST_STORED, k, sz, 1'b1);
                end
            end
            OP_LOOKUP:
            begin
                if (hit_slot < 0)
                    note(ST_MISS, k, 32'd0, 1'b1);
                else
                begin
                    for (int i = 0; i < ENTRIES; i++)
                        if (i != hit_slot && dir_valid[i] && dir_age[i] < dir_age[hit_slot])
                            dir_age[i]++;
                    dir_age[hit_slot] = 0;
                    note(ST_HIT, k, dir_sizes[hit_slot], 1'b1);
                end
            end
            OP_CLEAR:
            begin
                for (int i = 0; i < ENTRIES; i++)
                begin
                    dir_valid[i] = 1'b0;
                    dir_age[i] = 0;
                end
                dir_bytes = 32'd0;
                note(ST_CLEARED, 32'd0, 32'd0, 1'b1);
            end
            default:
            begin
            end
        endcase
    endfunction

    // send one command transaction, with random idle before it
    task automatic send_command(input opcode_t op, input logic [31:0] k,
                                input logic [31:0] sz);
        while ($urandom_range(99) < push_idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push <= 1'b1;
        opcode <= op;
        resource_key <= k;
        resource_size <= sz;
        @(posedge clk);
        while (full)
            @(posedge clk);
        predict_command(op, k, sz);
        if (op == OP_PUT)
            recent_keys.insert(recent_keys.size(), k);
        if (recent_keys.size() > 24)
            void'(recent_keys.pop_front());
    endtask

    // wait until all results have drained, then let the sequencer settle
    task automatic drain();
        int guard;
        guard = 0;
        push <= 1'b0;
        while (expected_results.size() != 0 && guard < 200000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (ENTRIES + 8) @(posedge clk);
    endtask

    task automatic write_limit(input logic [31:0] value);
        drain();
        cfg_valid <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        dir_limit = value;
    endtask

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
        begin
            if (expected_results.size() == 0)
            begin
                report_mismatch("unexpected result status", {29'd0, status}, 32'd0);
            end
            else
            begin
                result_t w;
                w = expected_results.pop_front();
                if (status !== w.status)
                    report_mismatch("status", {29'd0, status}, {29'd0, w.status});
                if (entry_key !== w.key) report_mismatch("entry_key", entry_key, w.key);
                if (entry_size !== w.size) report_mismatch("entry_size", entry_size, w.size);
                if (bytes_used !== w.used) report_mismatch("bytes_used", bytes_used, w.used);
                if (last !== w.last)
                    report_mismatch("last", {31'd0, last}, {31'd0, w.last});
            end
        end
    end

    // result side idling
    always @(posedge clk)
        pop <= ($urandom_range(99) >= pop_idle_pct);

    function automatic logic [31:0] pick_key();
        if (recent_keys.size() != 0 && $urandom_range(99) < 70)
            return recent_keys[$urandom_range(recent_keys.size() - 1)];
        return $urandom_range(40);
    endfunction

    // directed extremes and every status
    task automatic test_directed();
        send_command(OP_LOOKUP, 32'h0, 32'h0);
        send_command(OP_PUT, 32'hFFFF_FFFF, 32'h0);
        send_command(OP_PUT, 32'h0, 32'd16777216);
        send_command(OP_PUT, 32'h1, 32'd16777217);
        send_command(OP_PUT, 32'h0, 32'd5);
        send_command(OP_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_command(OP_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_command(OP_LOOKUP, 32'h5555_5555, 32'h0);
        send_command(OP_CLEAR, 32'hAAAA_AAAA, 32'h5555_5555);
        send_command(OP_LOOKUP, 32'h0, 32'h0);
        write_limit(32'hFFFF_FFFF);
        send_command(OP_PUT, 32'hAAAA_AAAA, 32'hFFFF_FFFF);
        send_command(OP_PUT, 32'h5555_5555, 32'h1);
        send_command(OP_PUT, 32'h5555_5555, 32'h1);
        write_limit(32'd1);
        send_command(OP_PUT, 32'h7, 32'h1);
        send_command(OP_PUT, 32'h8, 32'h2);
        send_command(OP_PUT, 32'h8, 32'h0);
    endtask

    // table full: eighteen zero-size puts force an eviction by count
    task automatic test_full_table();
        write_limit(32'd1000);
        for (int i = 0; i < ENTRIES + 2; i++)
            send_command(OP_PUT, 32'h100 + i, 32'd0);
        send_command(OP_LOOKUP, 32'h102, 32'h0);
        send_command(OP_PUT, 32'h200, 32'd1000);
    endtask

    // lowered limit, eviction deferred to the next put
    task automatic test_lowered_limit();
        write_limit(32'd100);
        for (int i = 0; i < 10; i++)
            send_command(OP_PUT, 32'h300 + i, 32'd9);
        write_limit(32'd20);
        send_command(OP_LOOKUP, 32'h300, 32'h0);
        send_command(OP_PUT, 32'h400, 32'd3);
    endtask

    // random traffic over several limits
    task automatic test_random(input int count);
        logic [31:0] limits [4];
        opcode_t op;
        int r;
        limits[0] = 32'd64;
        limits[1] = 32'd200;
        limits[2] = 32'hFFFF_FFFF;
        limits[3] = LIMIT_RESET;
        for (int n = 0; n < count; n++)
        begin
            if (n % 100 == 0)
                write_limit(limits[(n / 100) % 4]);
            // long stretch without idling, then a full pause
            if (n == 150)
            begin
                push_idle_pct = 0;
                pop_idle_pct = 0;
            end
            if (n == 230)
            begin
                push_idle_pct = 30;
                pop_idle_pct = 30;
                drain();
            end
            r = $urandom_range(99);
            op = (r < 55) ? OP_PUT : (r < 90) ? OP_LOOKUP : (r < 95) ? OP_CLEAR : OP_NONE;
            if (r % 7 == 0)
                send_command(op, $urandom, $urandom);
            else
                send_command(op, pick_key(), $urandom_range(dir_limit < 40 ? dir_limit : 40));
        end
    endtask

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        push = 1'b0;
        pop = 1'b0;
        opcode = OP_NONE;
        resource_key = 32'd0;
        resource_size = 32'd0;
        cfg_valid = 1'b0;
        cfg_data = 32'd0;
        error_count = 0;
        push_idle_pct = 30;
        pop_idle_pct = 30;
        dir_limit = LIMIT_RESET;
        dir_bytes = 32'd0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            dir_valid[i] = 1'b0;
            dir_age[i] = 0;
            dir_keys[i] = 32'd0;
            dir_sizes[i] = 32'd0;
        end
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_full_table();
        test_lowered_limit();
        test_random(360);
        drain();
        if (error_count == 0 && expected_results.size() == 0)
            $display("byte_budget_lru_cache_directory_unit_tb: PASS");
        else
            $display("byte_budget_lru_cache_directory_unit_tb: FAIL");
        $finish;
    end

    // run limit
    initial
    begin
        #20ms;
        $display("byte_budget_lru_cache_directory_unit_tb: FAIL");
        $finish;
    end

endmodule

// ===== sim.f =====
sv/bblru_pkg.sv
sv/bblru_front.sv
sv/bblru_back.sv
sv/byte_budget_lru_cache_directory_unit.sv
tb/byte_budget_lru_cache_directory_unit_tb.sv
